// File: design/ise_pkg.sv
// ise_pkg: shared constants and control structs for the insertion sort engine
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps

package ise_pkg;

    localparam int DATA_W   = 32;
    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic insert;
        logic drop;
        logic shift;
    } ise_cmd_t;

    typedef struct packed {
        logic full;
        logic last_one;
    } ise_status_t;

endpackage

// File: design/ise_datapath.sv
// ise_datapath: row of sorted cells with the element count and the drop flag
// depends on ise_pkg; driven by ise_ctrl through ise_cmd_t
`timescale 1ns / 1ps

module ise_datapath
    import ise_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ise_cmd_t                 cmd,
    input  logic signed [DATA_W-1:0] value,
    output ise_status_t              status,
    output logic signed [DATA_W-1:0] sorted_value,
    output logic                     overflow
);

    logic signed [DATA_W-1:0] store_reg [CAPACITY];
    logic signed [DATA_W-1:0] store_next [CAPACITY];
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     dropped_reg;
    logic                     dropped_next;
    logic [CAPACITY-1:0]      gt;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [DATA_W-1:0] prev_val;
            logic                     prev_gt;
            logic signed [DATA_W-1:0] up_val;

            // empty cells count as greater than the new value
            assign gt[g] = (CNT_W'(g) >= count_reg) || (store_reg[g] > value);

            if (g == 0)
            begin : g_first
                assign prev_val = value;
                assign prev_gt  = 1'b0;
            end
            else
            begin : g_rest
                assign prev_val = store_reg[g-1];
                assign prev_gt  = gt[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_top
                assign up_val = store_reg[g];
            end
            else
            begin : g_mid
                assign up_val = store_reg[g+1];
            end

            always_comb
            begin
                store_next[g] = store_reg[g];
                if (cmd.insert && gt[g])
                begin
                    store_next[g] = prev_gt ? prev_val : value;
                end
                else if (cmd.shift)
                begin
                    store_next[g] = up_val;
                end
            end

            always_ff @(posedge clk)
            begin
                store_reg[g] <= store_next[g];
            end
        end
    endgenerate

    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.shift)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.drop)
        begin
            dropped_next = 1'b1;
        end
        else if (cmd.shift && status.last_one)
        begin
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    assign status.full     = (count_reg == CNT_W'(CAPACITY));
    assign status.last_one = (count_reg == CNT_W'(1));
    assign sorted_value    = store_reg[0];
    assign overflow        = dropped_reg;

endmodule

// File: design/ise_ctrl.sv
// ise_ctrl: collect / emit state machine and channel handshakes
// depends on ise_pkg; commands ise_datapath
`timescale 1ns / 1ps

module ise_ctrl
    import ise_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        end_of_list,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        last_result,
    input  ise_status_t status,
    output ise_cmd_t    cmd
);

    localparam logic ST_COLLECT = 1'b0;
    localparam logic ST_EMIT    = 1'b1;

    logic state_reg;
    logic state_next;
    logic item_take;
    logic result_take;

    assign item_stall   = (state_reg == ST_EMIT);
    assign result_valid = (state_reg == ST_EMIT);
    assign last_result  = status.last_one;
    assign item_take    = item_valid && !item_stall;
    assign result_take  = result_valid && !result_stall;

    assign cmd.insert = item_take && !status.full;
    assign cmd.drop   = item_take && status.full;
    assign cmd.shift  = result_take;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (item_take && end_of_list)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (result_take && status.last_one)
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: design/insertion_sort_engine.sv
// insertion_sort_engine: top level joining the controller and the datapath
// depends on ise_pkg, ise_ctrl and ise_datapath
`timescale 1ns / 1ps
//
// usage
// - item channel (item_valid / item_stall): one signed 32-bit value per
//   request; end_of_list marks the final element, which is itself sorted
// - each element goes into a row of 32 cells that compare against it at once
//   and shift larger entries up, so an element is taken every cycle while a
//   list is being collected; equal values keep their arrival order
// - elements beyond 32 are dropped and the list's results carry overflow
// - in the cycle after the end_of_list request is taken, result_valid rises and
//   the list leaves in ascending order from the bottom cell, one result per
//   cycle while result_stall is low; last_result marks the final one
// - item_stall is high for the whole output phase, so a new list is taken
//   only once every result of the previous list has left
// - while result_stall is high the cells hold and the result stays steady
// - reset clears the count, the drop flag and the state; the block is then
//   ready for a new list at once
//
module insertion_sort_engine
    import ise_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     end_of_list,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic signed [DATA_W-1:0] sorted_value,
    output logic                     last_result,
    output logic                     overflow
);

    ise_cmd_t    cmd;
    ise_status_t status;

    ise_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .end_of_list  (end_of_list),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .last_result  (last_result),
        .status       (status),
        .cmd          (cmd)
    );

    ise_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .value        (value),
        .status       (status),
        .sorted_value (sorted_value),
        .overflow     (overflow)
    );

endmodule

// File: design/ise_checker.sv
// ise_checker: port-level assertions for insertion_sort_engine
// depends on ise_pkg; attached to the top level by the bind below
`timescale 1ns / 1ps

module ise_checker
    import ise_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     item_valid,
    input logic                     item_stall,
    input logic                     end_of_list,
    input logic                     result_valid,
    input logic                     result_stall,
    input logic signed [DATA_W-1:0] sorted_value,
    input logic                     last_result,
    input logic                     overflow
);

    // no new request is taken while results are going out
    a_no_take_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> item_stall)
        else $error("request taken during output phase");

    // the final element of a list starts the output phase
    a_emit_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && end_of_list) |=> result_valid)
        else $error("no results after end of list");

    // results ascend and continue until the marked one
    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !last_result)
            |=> (result_valid && (sorted_value >= $past(sorted_value))))
        else $error("results out of order or cut short");

    // the run ends after the marked result
    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && last_result) |=> !result_valid)
        else $error("results continue past the last one");

    // a stalled result holds
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall)
            |=> (result_valid && $stable(sorted_value) && $stable(last_result)
                 && $stable(overflow)))
        else $error("stalled result changed");

endmodule

bind insertion_sort_engine ise_checker u_ise_checker (.*);
